// ----- rtl/core/hscr_pkg.sv -----
// Shared types and constants for the history strip chart raster.
`timescale 1ns / 1ps

package hscr_pkg;

  // Operation codes carried on the op field.
  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_APPEND  = 2'd1,
    OP_READ    = 2'd2
  } op_t;

  // Field widths fixed by the interface.
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned POWER_W  = 32;
  localparam int unsigned PAGE_W   = 3;
  localparam int unsigned COLUMN_W = 7;
  localparam int unsigned COUNT_W  = 5;

  // Column split: upper bits pick the sample, low bits the interpolation step.
  localparam int unsigned STEP_W   = 3;
  localparam int unsigned SLOT_W   = COLUMN_W - STEP_W;

  // Chart values are handled in power format: 20 fractional bits.
  localparam int unsigned UNIT_BITS  = 20;
  localparam int unsigned VOLT_ALIGN = 10;
  localparam int unsigned ROW_LSB    = UNIT_BITS - 3;

  // Signed working width for interpolated values.
  localparam int unsigned VAL_W = 34;
  localparam logic signed [VAL_W-1:0] UNIT_VAL = 34'sd1048576;

  // Row zero is the lowest pixel of a page, drawn in bit 7.
  localparam logic [7:0] PIX_LOWEST = 8'h80;

endpackage

// ----- rtl/core/history_strip_chart_raster.sv -----
// Top level of the history strip chart raster: sample ring and page byte pipeline.
`timescale 1ns / 1ps

// History strip chart raster. Holds a ring of up to HISTORY_DEPTH voltage and
// power samples and rasterises them into OLED page bytes, one input word per
// clock cycle sustained while out_ready is held high. A word is accepted on
// in_valid and in_ready; its result passes the stage 1 and stage 2 registers
// into the output register. The accept edge does the ring bookkeeping, the
// 16 x 16 power multiply and the store write, and launches the two store reads
// (current and next sample); the second stage forms the interpolation step,
// the third the interpolated value and the pixel byte. Every stage holds while
// the one after it is full, so bubbles close up and in_ready stays high
// whenever the output register is empty or being drained. chart_mode is
// written through cfg_we and cfg_wdata and must only change while no word is
// in flight. After reset the ring holds one all-zero sample; the store needs
// no clearing pass.
module history_strip_chart_raster #(
  parameter int unsigned HISTORY_DEPTH = 16,
  parameter int unsigned CHART_PAGES   = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic                          cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    op,
  input  logic [hscr_pkg::SAMPLE_W-1:0] voltage,
  input  logic [hscr_pkg::SAMPLE_W-1:0] current,
  input  logic [hscr_pkg::PAGE_W-1:0]   page,
  input  logic [hscr_pkg::COLUMN_W-1:0] column,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    pixel_byte,
  output logic [hscr_pkg::COUNT_W-1:0]  entry_count
);

  localparam int unsigned IW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned SW = IW + hscr_pkg::SLOT_W + 1;
  localparam logic [IW-1:0] LAST_SLOT = IW'(HISTORY_DEPTH - 1);
  localparam int unsigned VW = hscr_pkg::VAL_W;

  // ---------------------------------------------------------------------
  // Handshake: each stage advances when the next one is empty or moving.
  // ---------------------------------------------------------------------
  logic v1, v2;
  logic out_en, en2, en1, accept;

  assign out_en   = !out_valid || out_ready;
  assign en2      = !v2 || out_en;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign accept   = in_valid && en1;

  // ---------------------------------------------------------------------
  // Configuration register
  // ---------------------------------------------------------------------
  logic chart_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      chart_mode <= 1'b0;
    end else if (cfg_we) begin
      chart_mode <= cfg_wdata;
    end
  end

  // ---------------------------------------------------------------------
  // Ring bookkeeping. count always equals the span from oldest to newest.
  // ---------------------------------------------------------------------
  logic [IW-1:0] oldest, oldest_next;
  logic [IW-1:0] newest, newest_next;
  logic [CW-1:0] count, count_next;
  logic [IW-1:0] oldest_step, newest_step;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [hscr_pkg::POWER_W-1:0] wr_power;

  assign oldest_step = (oldest == LAST_SLOT) ? '0 : oldest + IW'(1);
  assign newest_step = (newest == LAST_SLOT) ? '0 : newest + IW'(1);
  assign wr_power    = hscr_pkg::POWER_W'(voltage) * hscr_pkg::POWER_W'(current);

  always_comb begin
    oldest_next = oldest;
    newest_next = newest;
    count_next  = count;
    wr_en       = 1'b0;
    wr_addr     = newest_step;
    if (accept) begin
      case (op)
        hscr_pkg::OP_RESTART: begin
          // Restart: the ring holds just the new sample in slot zero.
          oldest_next = '0;
          newest_next = '0;
          count_next  = CW'(1);
          wr_en       = 1'b1;
          wr_addr     = '0;
        end
        hscr_pkg::OP_APPEND: begin
          // Append: advance newest, drop the oldest when the ring is full.
          newest_next = newest_step;
          if (newest_step == oldest) begin
            oldest_next = oldest_step;
          end
          if (count != CW'(HISTORY_DEPTH)) begin
            count_next = count + CW'(1);
          end
          wr_en   = 1'b1;
          wr_addr = newest_step;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oldest <= '0;
      newest <= '0;
      count  <= CW'(1);
    end else begin
      oldest <= oldest_next;
      newest <= newest_next;
      count  <= count_next;
    end
  end

  // ---------------------------------------------------------------------
  // Read address: sample slot counted from the oldest, wrapped once.
  // The sum stays below twice the depth whenever the slot is in range.
  // ---------------------------------------------------------------------
  logic [hscr_pkg::SLOT_W-1:0] slot;
  logic [hscr_pkg::STEP_W-1:0] step_j;
  logic [SW-1:0]               slot_sum;
  logic [IW-1:0]               rd_cur, rd_nxt;
  logic                        page_bad, slot_bad, read_zero;

  assign slot     = column[hscr_pkg::COLUMN_W-1:hscr_pkg::STEP_W];
  assign step_j   = column[hscr_pkg::STEP_W-1:0];
  assign slot_sum = SW'(oldest) + SW'(slot);
  assign rd_cur   = (slot_sum >= SW'(HISTORY_DEPTH)) ?
                    IW'(slot_sum - SW'(HISTORY_DEPTH)) : IW'(slot_sum);
  assign rd_nxt   = (rd_cur == LAST_SLOT) ? '0 : rd_cur + IW'(1);

  assign page_bad = 4'(page) >= 4'(CHART_PAGES);
  assign slot_bad = 8'(slot) >= 8'(count);

  // Blank the byte: non-read ops, off-chart page, slot past newest, gap columns
  // in voltage mode, and power-mode interpolation steps past the newest sample.
  always_comb begin
    read_zero = 1'b1;
    case (op)
      hscr_pkg::OP_READ: begin
        read_zero = page_bad || slot_bad ||
                    ((step_j != '0) && (chart_mode || (rd_cur == newest)));
      end
      default: begin
        read_zero = 1'b1;
      end
    endcase
  end

  logic [hscr_pkg::SAMPLE_W-1:0] rd_volt;
  logic [hscr_pkg::POWER_W-1:0]  rd_pc, rd_pn;

  hscr_store #(
    .DEPTH (HISTORY_DEPTH),
    .IW    (IW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_volt  (voltage),
    .wr_power (wr_power),
    .rd_en    (accept),
    .rd_cur   (rd_cur),
    .rd_nxt   (rd_nxt),
    .rd_volt  (rd_volt),
    .rd_pc    (rd_pc),
    .rd_pn    (rd_pn)
  );

  // ---------------------------------------------------------------------
  // Stage 1: word fields alongside the store read data.
  // ---------------------------------------------------------------------
  logic                         s1_zero;
  logic                         s1_volt_mode;
  logic [hscr_pkg::STEP_W-1:0]  s1_j;
  logic [hscr_pkg::PAGE_W-1:0]  s1_page;
  logic [hscr_pkg::COUNT_W-1:0] s1_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_zero      <= read_zero;
      s1_volt_mode <= chart_mode;
      s1_j         <= step_j;
      s1_page      <= page;
      s1_count     <= hscr_pkg::COUNT_W'(count_next);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: value relative to the page floor, and the step toward the next
  // sample (difference floored by eight through the arithmetic shift).
  // ---------------------------------------------------------------------
  logic signed [VW-1:0] pc_s, pn_s, volt_s, floor_s, base_rel, diff_s, step_d;
  logic                         s2_zero;
  logic [hscr_pkg::COUNT_W-1:0] s2_count;
  logic signed [VW-1:0]         s2_base;
  logic signed [VW-1:0]         s2_step;
  logic [hscr_pkg::STEP_W-1:0]  s2_j;

  assign pc_s     = signed'(VW'(rd_pc));
  assign pn_s     = signed'(VW'(rd_pn));
  assign volt_s   = signed'(VW'(rd_volt) << hscr_pkg::VOLT_ALIGN);
  assign floor_s  = signed'(VW'(3'd7 - s1_page) << hscr_pkg::UNIT_BITS);
  assign base_rel = (s1_volt_mode ? volt_s : pc_s) - floor_s;
  assign diff_s   = pn_s - pc_s;
  assign step_d   = diff_s >>> 3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  // The next sample is only meaningful on an interpolation step in power
  // mode; hold the step at zero otherwise, as that slot may be unwritten.
  always_ff @(posedge clk) begin
    if (en2) begin
      s2_zero  <= s1_zero;
      s2_count <= s1_count;
      s2_base  <= base_rel;
      s2_step  <= (s1_volt_mode || (s1_j == '0)) ? '0 : step_d;
      s2_j     <= s1_volt_mode ? '0 : s1_j;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: interpolated value and pixel row into the output register.
  // A value exactly at the page top gives row eight; clamp it to row seven.
  // ---------------------------------------------------------------------
  logic signed [VW+3:0] step_prod;
  logic signed [VW-1:0] rel_val;
  logic [2:0]           row;
  logic [7:0]           pix_next;

  assign step_prod = s2_step * signed'({1'b0, s2_j});
  assign rel_val   = s2_base + signed'(step_prod[VW-1:0]);

  always_comb begin
    row = rel_val[hscr_pkg::ROW_LSB +: 3];
    if (rel_val == hscr_pkg::UNIT_VAL) begin
      row = 3'd7;
    end
    pix_next = hscr_pkg::PIX_LOWEST >> row;
    if (s2_zero || rel_val[VW-1] || (rel_val == '0) || (rel_val > hscr_pkg::UNIT_VAL)) begin
      pix_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      pixel_byte  <= pix_next;
      entry_count <= s2_count;
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with an empty output register");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count <= CW'(HISTORY_DEPTH)))
    else $error("ring count out of range");

  a_span_matches_count: assert property (@(posedge clk) disable iff (rst)
    ((newest >= oldest) && (int'(newest) - int'(oldest) + 1 == int'(count))) ||
    ((newest < oldest) &&
     (int'(newest) + int'(HISTORY_DEPTH) - int'(oldest) + 1 == int'(count))))
    else $error("ring pointers disagree with count");

  a_restart_count: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == hscr_pkg::OP_RESTART)) |=> (count == CW'(1)))
    else $error("restart did not leave one sample");

  a_single_pixel: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (pixel_byte != '0)) |-> $onehot(pixel_byte))
    else $error("page byte lights more than one row");

endmodule

// ----- rtl/core/hscr_store.sv -----
// Sample store: voltage and power memories with registered read ports.
`timescale 1ns / 1ps

module hscr_store #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned IW    = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [IW-1:0]                 wr_addr,
  input  logic [hscr_pkg::SAMPLE_W-1:0] wr_volt,
  input  logic [hscr_pkg::POWER_W-1:0]  wr_power,
  input  logic                          rd_en,
  input  logic [IW-1:0]                 rd_cur,
  input  logic [IW-1:0]                 rd_nxt,
  output logic [hscr_pkg::SAMPLE_W-1:0] rd_volt,
  output logic [hscr_pkg::POWER_W-1:0]  rd_pc,
  output logic [hscr_pkg::POWER_W-1:0]  rd_pn
);

  logic [hscr_pkg::SAMPLE_W-1:0] volt_mem  [DEPTH];
  logic [hscr_pkg::POWER_W-1:0]  power_mem [DEPTH];

  logic [hscr_pkg::SAMPLE_W-1:0] volt_q;
  logic [hscr_pkg::POWER_W-1:0]  pc_q;
  logic [hscr_pkg::POWER_W-1:0]  pn_q;

  // Slot zero is the only entry the ring can reach before it is written;
  // it reads as zero until its first write.
  logic fresh;
  logic cur_fresh;
  logic nxt_fresh;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      volt_mem[wr_addr]  <= wr_volt;
      power_mem[wr_addr] <= wr_power;
    end
    if (rd_en) begin
      volt_q    <= volt_mem[rd_cur];
      pc_q      <= power_mem[rd_cur];
      pn_q      <= power_mem[rd_nxt];
      cur_fresh <= fresh && (rd_cur == '0);
      nxt_fresh <= fresh && (rd_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh <= 1'b1;
    end else if (wr_en && (wr_addr == '0)) begin
      fresh <= 1'b0;
    end
  end

  assign rd_volt = cur_fresh ? '0 : volt_q;
  assign rd_pc   = cur_fresh ? '0 : pc_q;
  assign rd_pn   = nxt_fresh ? '0 : pn_q;

endmodule
